// ===== rtl/core/egcd_pkg.sv =====
// Shared widths, command/status structs for the extended GCD block.
package egcd_pkg;

  // Coefficient width; operands are one bit narrower
  localparam int WIDTH = 32;
  localparam int OP_W  = WIDTH - 1;
  // Division step counter width (counts OP_W-1 down to 0)
  localparam int CNT_W = $clog2(OP_W);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture a new item and order the operands
    logic div_start;  // clear partial remainder and accumulators
    logic div_step;   // one restoring division bit
    logic update;     // rotate remainders and coefficients
    logic out_load;   // write the result register
  } egcd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic rb_zero;    // smaller remainder has reached zero
  } egcd_sts_t;

endpackage

// ===== rtl/core/extended_gcd.sv =====
// Extended GCD: each item is loaded, runs k Euclid steps, then is written to the result register.
// Each Euclid step is a check state, a bit-serial restoring division and an update state.
// One item is in work at a time; a finished result waits in an output register
// while the next item is accepted.
// Synchronous active-low reset clears the controller and output valid; no result is pending.
module extended_gcd (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [egcd_pkg::OP_W-1:0]   in_operand_n,
  input  logic [egcd_pkg::OP_W-1:0]   in_operand_p,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [egcd_pkg::OP_W-1:0]   out_divisor,
  output logic signed [egcd_pkg::WIDTH-1:0] out_coef_n,
  output logic signed [egcd_pkg::WIDTH-1:0] out_coef_p,
  output logic                        out_bad_input
);
  import egcd_pkg::*;

  egcd_cmd_t        cmd;
  egcd_sts_t        sts;
  logic [WIDTH-1:0] coef_n_w, coef_p_w;

  // Sequencer
  egcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and result storage
  egcd_dp u_dp (
    .clk           (clk),
    .in_operand_n  (in_operand_n),
    .in_operand_p  (in_operand_p),
    .cmd           (cmd),
    .sts           (sts),
    .out_divisor   (out_divisor),
    .out_coef_n    (coef_n_w),
    .out_coef_p    (coef_p_w),
    .out_bad_input (out_bad_input)
  );

  assign out_coef_n = $signed(coef_n_w);
  assign out_coef_p = $signed(coef_p_w);

endmodule

// ===== rtl/core/egcd_ctrl.sv =====
// Controller state machine: sequences Euclid steps and the output handshake.
module egcd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  egcd_pkg::egcd_sts_t sts,
  output egcd_pkg::egcd_cmd_t cmd
);
  import egcd_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  // Result register may be overwritten when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.rb_zero) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.div_start = 1'b1;
          cnt_nxt       = CNT_W'(OP_W - 1);
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/egcd_dp.sv =====
// Datapath: remainder pair, Bezout coefficients, bit-serial division, result register.
module egcd_dp (
  input  logic                      clk,
  input  logic [egcd_pkg::OP_W-1:0] in_operand_n,
  input  logic [egcd_pkg::OP_W-1:0] in_operand_p,
  input  egcd_pkg::egcd_cmd_t       cmd,
  output egcd_pkg::egcd_sts_t       sts,
  output logic [egcd_pkg::OP_W-1:0] out_divisor,
  output logic [egcd_pkg::WIDTH-1:0] out_coef_n,
  output logic [egcd_pkg::WIDTH-1:0] out_coef_p,
  output logic                      out_bad_input
);
  import egcd_pkg::*;

  logic [OP_W-1:0]  ra_r, rb_r, rem_r, dvd_r;
  logic [WIDTH-1:0] xa_r, xb_r, ya_r, yb_r, tx_r, ty_r;
  logic             n_big_r, bad_r;
  logic [OP_W-1:0]  div_r;
  logic [WIDTH-1:0] cn_r, cp_r;
  logic             bad_out_r;

  logic [WIDTH-1:0] rem_sh, rb_ext, rem_diff;
  logic             qbit;
  logic [WIDTH-1:0] x_add, y_add;
  logic             n_ge_p;

  assign sts.rb_zero = (rb_r == '0);
  assign n_ge_p      = (in_operand_n >= in_operand_p);

  // One restoring division bit, with the quotient folded into q*xb and q*yb
  assign rem_sh   = {rem_r, dvd_r[OP_W-1]};
  assign rb_ext   = {1'b0, rb_r};
  assign rem_diff = rem_sh - rb_ext;
  assign qbit     = (rem_sh >= rb_ext);
  assign x_add    = qbit ? xb_r : '0;
  assign y_add    = qbit ? yb_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // Larger operand first; equal operands count operand_n as larger
      ra_r    <= n_ge_p ? in_operand_n : in_operand_p;
      rb_r    <= n_ge_p ? in_operand_p : in_operand_n;
      n_big_r <= n_ge_p;
      bad_r   <= (in_operand_n == '0) && (in_operand_p == '0);
      xa_r    <= WIDTH'(1);
      xb_r    <= '0;
      ya_r    <= '0;
      yb_r    <= WIDTH'(1);
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      dvd_r <= ra_r;
      tx_r  <= '0;
      ty_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= qbit ? rem_diff[OP_W-1:0] : rem_sh[OP_W-1:0];
      dvd_r <= {dvd_r[OP_W-2:0], 1'b0};
      tx_r  <= {tx_r[WIDTH-2:0], 1'b0} + x_add;
      ty_r  <= {ty_r[WIDTH-2:0], 1'b0} + y_add;
    end
    // Multiply by [[0,1],[1,-q]]
    if (cmd.update) begin
      ra_r <= rb_r;
      rb_r <= rem_r;
      xa_r <= xb_r;
      xb_r <= xa_r - tx_r;
      ya_r <= yb_r;
      yb_r <= ya_r - ty_r;
    end
    // Result register, coefficients mapped back to operand order
    if (cmd.out_load) begin
      bad_out_r <= bad_r;
      if (bad_r) begin
        div_r <= '0;
        cn_r  <= '0;
        cp_r  <= '0;
      end else begin
        div_r <= ra_r;
        cn_r  <= n_big_r ? xa_r : ya_r;
        cp_r  <= n_big_r ? ya_r : xa_r;
      end
    end
  end

  assign out_divisor   = div_r;
  assign out_coef_n    = cn_r;
  assign out_coef_p    = cp_r;
  assign out_bad_input = bad_out_r;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the extended GCD block: queued driver, monitor and predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import egcd_pkg::*;

  // Cycle limit allows several times the slowest whole run
  localparam int CYCLE_LIMIT  = 2_500_000;
  localparam int DRAIN_CYCLES = 1600;
  localparam int RANDOM_ITEMS = 390;
  localparam int MAX_REPORTS  = 40;
  localparam logic [OP_W-1:0] OP_MAX = {OP_W{1'b1}};

  typedef struct packed {
    logic [OP_W-1:0] n;
    logic [OP_W-1:0] p;
  } operand_pair_t;

  // Expected result, with the operands kept for the mismatch report
  typedef struct packed {
    logic [OP_W-1:0]  n;
    logic [OP_W-1:0]  p;
    logic [OP_W-1:0]  divisor;
    logic [WIDTH-1:0] coef_n;
    logic [WIDTH-1:0] coef_p;
    logic             bad;
  } gcd_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_operand_n = '0;
  logic [OP_W-1:0] in_operand_p = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OP_W-1:0] out_divisor;
  logic signed [WIDTH-1:0] out_coef_n;
  logic signed [WIDTH-1:0] out_coef_p;
  logic out_bad_input;

  operand_pair_t pairs_to_send[$];
  gcd_result_t   results_due[$];

  int item_total     = 0;
  int directed_total = 0;
  int accepted_count = 0;
  int checked_count  = 0;
  int zero_pairs     = 0;
  int fail_count     = 0;
  int cycle_count    = 0;

  extended_gcd u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operand_n  (in_operand_n),
    .in_operand_p  (in_operand_p),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_divisor   (out_divisor),
    .out_coef_n    (out_coef_n),
    .out_coef_p    (out_coef_p),
    .out_bad_input (out_bad_input)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Euclid on (larger, smaller) with wrapping coefficients, mapped back to input order
  function automatic gcd_result_t bezout_predict(input logic [OP_W-1:0] n,
                                                 input logic [OP_W-1:0] p);
    logic [63:0] ra, rb, xa, ya, xb, yb, q, rn, xn, yn;
    logic n_big;
    gcd_result_t r;
    r = '0;
    r.n = n;
    r.p = p;
    if (n == 0 && p == 0) begin
      r.bad = 1'b1;
    end else if (n == 0) begin
      r.divisor = p;
      r.coef_p  = 1;
    end else if (p == 0) begin
      r.divisor = n;
      r.coef_n  = 1;
    end else begin
      // equal operands count n as the larger
      n_big = (n >= p);
      ra = n_big ? 64'(n) : 64'(p);
      rb = n_big ? 64'(p) : 64'(n);
      xa = 64'd1; ya = 64'd0;
      xb = 64'd0; yb = 64'd1;
      while (rb != 0) begin
        q  = ra / rb;
        rn = ra - q * rb;
        xn = xa - q * xb;
        yn = ya - q * yb;
        ra = rb; rb = rn;
        xa = xb; xb = xn;
        ya = yb; yb = yn;
      end
      r.divisor = ra[OP_W-1:0];
      r.coef_n  = n_big ? xa[WIDTH-1:0] : ya[WIDTH-1:0];
      r.coef_p  = n_big ? ya[WIDTH-1:0] : xa[WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic [OP_W-1:0] fib_at(input int k);
    logic [OP_W-1:0] a, b, t;
    a = 0;
    b = 1;
    for (int i = 0; i < k; i++) begin
      t = a + b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Random operand pair, weighted towards the interesting shapes
  function automatic operand_pair_t rand_pair();
    operand_pair_t pr;
    int unsigned kind, f, k;
    logic [31:0] w0, w1;
    kind = $urandom_range(0, 99);
    w0 = $urandom;
    w1 = $urandom;
    pr.n = w0[OP_W-1:0];
    pr.p = w1[OP_W-1:0];
    if (kind < 40) begin
      // full-width random, nothing to change
    end else if (kind < 55) begin
      // shared factor so the divisor is large
      f = $urandom_range(1, 65535);
      pr.n = OP_W'($urandom_range(0, 32767) * f);
      pr.p = OP_W'($urandom_range(0, 32767) * f);
    end else if (kind < 70) begin
      pr.n = OP_W'($urandom_range(0, 255));
      pr.p = OP_W'($urandom_range(0, 255));
    end else if (kind < 80) begin
      if (kind[0]) pr.n = OP_W'($urandom_range(1, 1000));
      else         pr.p = OP_W'($urandom_range(1, 1000));
    end else if (kind < 85) begin
      // consecutive Fibonacci numbers give the longest remainder chains
      k = $urandom_range(2, 46);
      pr.n = fib_at(k);
      pr.p = fib_at(k - 1);
      if (kind[0]) begin
        pr.n = fib_at(k - 1);
        pr.p = fib_at(k);
      end
    end else if (kind < 90) begin
      pr.p = pr.n;
    end else if (kind < 95) begin
      if (kind[0]) pr.n = '0;
      else         pr.p = '0;
    end else if (kind < 97) begin
      pr.n = '0;
      pr.p = '0;
    end else begin
      pr.n = OP_MAX - OP_W'($urandom_range(0, 3));
      pr.p = OP_MAX - OP_W'($urandom_range(0, 3));
    end
    return pr;
  endfunction

  task automatic queue_pair(input logic [OP_W-1:0] n, input logic [OP_W-1:0] p);
    operand_pair_t pr;
    pr.n = n;
    pr.p = p;
    pairs_to_send.push_back(pr);
  endtask

  // Idle rates: sender 26 / receiver 48, then swapped, then none
  function automatic int send_idle_pct();
    if (accepted_count * 3 < item_total)     return 26;
    if (accepted_count * 3 < item_total * 2) return 48;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (checked_count * 3 < item_total)     return 48;
    if (checked_count * 3 < item_total * 2) return 26;
    return 0;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got, input gcd_result_t ctx);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch for n=%0d p=%0d: expected %0h, got %0h",
                 $time, what, ctx.n, ctx.p, want, got);
    end
  endtask

  // Driver: predicts on each accepted item, then presents the next one or idles
  always @(posedge clk) begin : driver
    operand_pair_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        results_due.push_back(bezout_predict(in_operand_n, in_operand_p));
        if (in_operand_n == 0 && in_operand_p == 0) zero_pairs++;
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (pairs_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          nxt = pairs_to_send.pop_front();
          in_operand_n <= nxt.n;
          in_operand_p <= nxt.p;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest prediction
  always @(posedge clk) begin : monitor
    gcd_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t ns: unexpected result: expected none, got divisor=%0h",
                     $time, out_divisor);
        end else begin
          want = results_due.pop_front();
          check_field("divisor", 64'(want.divisor), 64'(out_divisor), want);
          check_field("coef_n", 64'(want.coef_n), 64'(unsigned'(out_coef_n)), want);
          check_field("coef_p", 64'(want.coef_p), 64'(unsigned'(out_coef_p)), want);
          check_field("bad_input", 64'(want.bad), 64'(out_bad_input), want);
        end
        checked_count++;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, results_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // zero operands, equal operands, extremes, longest chains, both orders
    queue_pair('0, '0);
    queue_pair('0, 31'd12345);
    queue_pair('0, OP_MAX);
    queue_pair(OP_MAX, '0);
    queue_pair(31'd1, '0);
    queue_pair(31'd7, 31'd7);
    queue_pair(OP_MAX, OP_MAX);
    queue_pair(31'd1, 31'd1);
    queue_pair(OP_MAX, 31'd1);
    queue_pair(31'd1, OP_MAX);
    queue_pair(OP_MAX, OP_MAX - 1);
    queue_pair(OP_MAX - 1, OP_MAX);
    queue_pair(31'd1836311903, 31'd1134903170);
    queue_pair(31'd1134903170, 31'd1836311903);
    queue_pair(31'd240, 31'd46);
    queue_pair(31'd46, 31'd240);
    queue_pair(31'h4000_0000, 31'h2000_0000);
    queue_pair(31'h5555_5555, 31'h2AAA_AAAA);
    queue_pair(31'h2AAA_AAAA, 31'h5555_5555);
    queue_pair(31'd3 * 31'd65521, 31'd5 * 31'd65521);
    directed_total = pairs_to_send.size();
    repeat (RANDOM_ITEMS) pairs_to_send.push_back(rand_pair());
    item_total = pairs_to_send.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pairs_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      fail_count++;
      $display("%0t ns: %0d results never arrived: expected %0d more, got 0",
               $time, results_due.size(), results_due.size());
    end

    $display("Sent %0d operand pairs (%0d directed), %0d of them both zero",
             accepted_count, directed_total, zero_pairs);
    $display("Checked %0d results over three idling phases, %0d mismatches",
             checked_count, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
